FILE: rtl/lea_pkg.sv
// lea_pkg: shared types, constants and round functions for the lea-128 encrypt pipeline
// used by lea_round_cell and lea128_block_encrypt; no dependencies
`default_nettype none

package lea_pkg;

  localparam int unsigned ROUNDS_DEF = 24;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned CFG_IDX_W  = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_WORD0 = 8'd0,
    CFG_KEY_WORD1 = 8'd1,
    CFG_KEY_WORD2 = 8'd2,
    CFG_KEY_WORD3 = 8'd3
  } cfg_idx_e;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic [3:0][WORD_W-1:0] x;
    logic [3:0][WORD_W-1:0] t;
  } stage_t;

  localparam word_t DELTA [4] = '{
    32'hc3efe9db, 32'h44626b02, 32'h79e27c8a, 32'h78df30ec
  };

  localparam int unsigned KEY_ROT [4] = '{1, 3, 6, 11};

  function automatic word_t rotl32(word_t v, int unsigned r);
    logic [4:0] s;
    s = r[4:0];
    return (v << s) | (v >> (6'd32 - {1'b0, s}));
  endfunction

  // key schedule step for round rnd
  function automatic logic [3:0][WORD_W-1:0] key_update(logic [3:0][WORD_W-1:0] t,
                                                        int unsigned rnd);
    logic [3:0][WORD_W-1:0] r;
    logic [1:0]             di;
    word_t                  k;
    di = rnd[1:0];
    for (int j = 0; j < 4; j++) begin
      k    = rotl32(DELTA[di], rnd + j);
      r[j] = rotl32(t[j] + k, KEY_ROT[j]);
    end
    return r;
  endfunction

  // one arx round with round key (t0, t1, t2, t1, t3, t1)
  function automatic logic [3:0][WORD_W-1:0] arx_round(logic [3:0][WORD_W-1:0] x,
                                                       logic [3:0][WORD_W-1:0] t);
    logic [3:0][WORD_W-1:0] n;
    n[0] = rotl32((x[0] ^ t[0]) + (x[1] ^ t[1]), 9);
    n[1] = rotl32((x[1] ^ t[2]) + (x[2] ^ t[1]), 27);
    n[2] = rotl32((x[2] ^ t[3]) + (x[3] ^ t[1]), 29);
    n[3] = x[0];
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/lea_round_cell.sv
// lea_round_cell: one arx round plus the key schedule step for the next round
// depends on lea_pkg
`default_nettype none

module lea_round_cell #(
  parameter int unsigned ROUND = 0
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire lea_pkg::stage_t stage_i,
  output logic                 valid_o,
  output lea_pkg::stage_t      stage_o
);

  logic            valid_q;
  lea_pkg::stage_t stage_d, stage_q;

  always_comb begin
    stage_d.x = lea_pkg::arx_round(stage_i.x, stage_i.t);
    stage_d.t = lea_pkg::key_update(stage_i.t, ROUND + 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

`default_nettype wire

FILE: rtl/lea128_block_encrypt.sv
// lea128_block_encrypt: lea-128 block encryption as a chain of round cells
// depends on lea_pkg and lea_round_cell
//
//   channel   handshake                   payload
//   input     start_i, busy_o             pt_word0_i .. pt_word3_i
//   result    done_o (one-cycle strobe)   ct_word0_o .. ct_word3_o
//   config    cfg_valid_i, cfg_ready_o    cfg_index_i, cfg_wdata_i
//
// one block accepted per cycle; each result passes through the input stage register,
// followed by one register per round cell
// busy_o is always low and cfg_ready_o always high
// reset clears the key words to zero and empties the pipeline
// the receiver cannot stall; done_o strobes for exactly one cycle per block
`default_nettype none

module lea128_block_encrypt #(
  parameter int unsigned ROUNDS = lea_pkg::ROUNDS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [31:0]                   pt_word0_i,
  input  wire logic [31:0]                   pt_word1_i,
  input  wire logic [31:0]                   pt_word2_i,
  input  wire logic [31:0]                   pt_word3_i,
  output logic                               done_o,
  output logic [31:0]                        ct_word0_o,
  output logic [31:0]                        ct_word1_o,
  output logic [31:0]                        ct_word2_o,
  output logic [31:0]                        ct_word3_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [lea_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]                   cfg_wdata_i
);

  localparam int unsigned LAT = ROUNDS + 1;

  logic [3:0][31:0] key_q, key_d;
  logic             accept;
  logic             entry_valid_q;
  lea_pkg::stage_t  entry_d, entry_q;
  logic             valid_c [ROUNDS+1];
  lea_pkg::stage_t  stage_c [ROUNDS+1];

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  // key words
  always_comb begin
    key_d = key_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        lea_pkg::CFG_KEY_WORD0: key_d[0] = cfg_wdata_i;
        lea_pkg::CFG_KEY_WORD1: key_d[1] = cfg_wdata_i;
        lea_pkg::CFG_KEY_WORD2: key_d[2] = cfg_wdata_i;
        lea_pkg::CFG_KEY_WORD3: key_d[3] = cfg_wdata_i;
        default: key_d = key_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  // input stage with first round key
  always_comb begin
    entry_d.x = {pt_word3_i, pt_word2_i, pt_word1_i, pt_word0_i};
    entry_d.t = lea_pkg::key_update(key_q, 0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= 1'b0;
    end else begin
      entry_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign valid_c[0] = entry_valid_q;
  assign stage_c[0] = entry_q;

  for (genvar g = 0; g < ROUNDS; g++) begin : g_round
    lea_round_cell #(
      .ROUND (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_c[g]),
      .stage_i (stage_c[g]),
      .valid_o (valid_c[g+1]),
      .stage_o (stage_c[g+1])
    );
  end

  assign done_o     = valid_c[ROUNDS];
  assign ct_word0_o = stage_c[ROUNDS].x[0];
  assign ct_word1_o = stage_c[ROUNDS].x[1];
  assign ct_word2_o = stage_c[ROUNDS].x[2];
  assign ct_word3_o = stage_c[ROUNDS].x[3];

  a_start_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT done_o)
    else $error("result strobe missing after start");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |-> ##LAT !done_o)
    else $error("result strobe without a start");

  a_key_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_valid_i |=> $stable(key_q))
    else $error("key changed without a config write");

endmodule

`default_nettype wire
